FILE: sv/gsdy_pkg.sv
// Shared types and constants of the Gaussian second y-derivative evaluation unit.
package gsdy_pkg;

  localparam int unsigned AddrW = 5;

  localparam logic [2:0] REG_CENTER_X   = 3'd0;
  localparam logic [2:0] REG_CENTER_Y   = 3'd1;
  localparam logic [2:0] REG_CENTER_Z   = 3'd2;
  localparam logic [2:0] REG_INV_VAR_X  = 3'd3;
  localparam logic [2:0] REG_INV_VAR_Y  = 3'd4;
  localparam logic [2:0] REG_INV_VAR_Z  = 3'd5;
  localparam logic [2:0] REG_INV_VAR_T  = 3'd6;
  localparam logic [2:0] REG_NORM       = 3'd7;

  localparam logic [1:0] FUNC_1D = 2'd0;
  localparam logic [1:0] FUNC_2D = 2'd1;
  localparam logic [1:0] FUNC_3D = 2'd2;
  localparam logic [1:0] FUNC_4D = 2'd3;

  localparam logic [31:0] IV_RESET   = 32'd65536;
  localparam logic [31:0] NORM_RESET = 32'd16777216;

  localparam logic [40:0] TERM_CAP  = 41'h100_0000_0000;
  localparam logic [40:0] ONE_Q16   = 41'd65536;
  localparam logic [22:0] E_CLAMP   = 23'd4194304;
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [30:0] ONE30     = 31'h4000_0000;
  localparam logic [7:0]  MAX_SHIFT = 8'd34;

  // Horner steps run k = 8 down to 1; v / k is (v * DIV_MUL) >> DIV_SHIFT, exact for v < 2^30
  localparam int unsigned HSTEPS = 8;
  localparam logic [30:0] DIV_MUL [HSTEPS] = '{
    31'd1, 31'd1227133514, 31'd1431655766, 31'd1717986919,
    31'd1, 31'd1431655766, 31'd1, 31'd1
  };
  localparam int unsigned DIV_SHIFT [HSTEPS] = '{3, 33, 33, 33, 2, 32, 1, 0};

  localparam logic [72:0] POS_MAX = 73'h0_7FFF_FFFF_FFFF;
  localparam logic [72:0] NEG_MAG = 73'h0_8000_0000_0000;
  localparam logic [47:0] KV_POS_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] KV_NEG_MIN = 48'h8000_0000_0000;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] coord_x;
    logic [31:0] coord_y;
    logic [31:0] coord_z;
    logic [31:0] t_offset;
  } req_t;

  typedef struct packed {
    logic [31:0] center_x;
    logic [31:0] center_y;
    logic [31:0] center_z;
    logic [31:0] inv_var_x;
    logic [31:0] inv_var_y;
    logic [31:0] inv_var_z;
    logic [31:0] inv_var_t;
    logic [31:0] norm_factor;
  } cfg_t;

  // exponent argument: x = fraction part (Q0.30), n = integer shift
  typedef struct packed {
    logic        zero;
    logic        neg;
    logic [40:0] m;
    logic [7:0]  n;
    logic [29:0] x;
  } arg_t;

  typedef struct packed {
    logic        zero;
    logic        neg;
    logic [40:0] m;
    logic [32:0] g;
  } expo_t;

endpackage

FILE: sv/gsdy_req_if.sv
// Request channel: dimension mode and sample coordinates.
interface gsdy_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic signed [31:0] coord_z;
  logic signed [31:0] t_offset;

  modport source (output valid, func, coord_x, coord_y, coord_z, t_offset, input ready);
  modport sink   (input valid, func, coord_x, coord_y, coord_z, t_offset, output ready);
endinterface

FILE: sv/gsdy_rsp_if.sv
// Result channel: kernel value and saturation flag.
interface gsdy_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] kernel_value;
  logic               saturated;

  modport source (output valid, kernel_value, saturated, input ready);
  modport sink   (input valid, kernel_value, saturated, output ready);
endinterface

FILE: sv/gsdy_regs.sv
// APB configuration register file.
module gsdy_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gsdy_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output gsdy_pkg::cfg_t              cfg_o
);

  gsdy_pkg::cfg_t cfg_q, cfg_d;
  logic [2:0]     idx;
  logic           wr_en;

  assign idx    = paddr[gsdy_pkg::AddrW-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        gsdy_pkg::REG_CENTER_X:  cfg_d.center_x    = pwdata;
        gsdy_pkg::REG_CENTER_Y:  cfg_d.center_y    = pwdata;
        gsdy_pkg::REG_CENTER_Z:  cfg_d.center_z    = pwdata;
        gsdy_pkg::REG_INV_VAR_X: cfg_d.inv_var_x   = pwdata;
        gsdy_pkg::REG_INV_VAR_Y: cfg_d.inv_var_y   = pwdata;
        gsdy_pkg::REG_INV_VAR_Z: cfg_d.inv_var_z   = pwdata;
        gsdy_pkg::REG_INV_VAR_T: cfg_d.inv_var_t   = pwdata;
        gsdy_pkg::REG_NORM:      cfg_d.norm_factor = pwdata;
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      gsdy_pkg::REG_CENTER_X:  prdata = cfg_q.center_x;
      gsdy_pkg::REG_CENTER_Y:  prdata = cfg_q.center_y;
      gsdy_pkg::REG_CENTER_Z:  prdata = cfg_q.center_z;
      gsdy_pkg::REG_INV_VAR_X: prdata = cfg_q.inv_var_x;
      gsdy_pkg::REG_INV_VAR_Y: prdata = cfg_q.inv_var_y;
      gsdy_pkg::REG_INV_VAR_Z: prdata = cfg_q.inv_var_z;
      gsdy_pkg::REG_INV_VAR_T: prdata = cfg_q.inv_var_t;
      gsdy_pkg::REG_NORM:      prdata = cfg_q.norm_factor;
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_x    <= '0;
      cfg_q.center_y    <= '0;
      cfg_q.center_z    <= '0;
      cfg_q.inv_var_x   <= gsdy_pkg::IV_RESET;
      cfg_q.inv_var_y   <= gsdy_pkg::IV_RESET;
      cfg_q.inv_var_z   <= gsdy_pkg::IV_RESET;
      cfg_q.inv_var_t   <= gsdy_pkg::IV_RESET;
      cfg_q.norm_factor <= gsdy_pkg::NORM_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: sv/gsdy_arg.sv
// Offsets, weighted squares, sum and split of the exponent argument (7 stages).
module gsdy_arg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  gsdy_pkg::req_t req_i,
  input  gsdy_pkg::cfg_t cfg_i,
  output logic           valid_o,
  output gsdy_pkg::arg_t arg_o
);

  function automatic logic [31:0] off_mag(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] d;
    d = {a[31], a} - {b[31], b};
    return d[32] ? 32'(33'd0 - d) : d[31:0];
  endfunction

  logic [6:0]  vld_q;
  logic [31:0] iv [4];
  logic [31:0] mag_d [4];
  logic [31:0] mag_q [4];
  logic [63:0] sq_q [4];
  logic [63:0] hi_q [4];
  logic [63:0] lo_q [4];
  logic [40:0] term_d [4];
  logic [40:0] term_q [4];
  logic [3:0]  zero_q;

  logic [42:0] sum;
  logic [41:0] half;
  logic [22:0] e_d, e_q;
  logic [40:0] m5_q, m6_q, m5_d;
  logic        neg5_q, neg6_q, neg5_d;
  logic        zero5_q, zero6_q;
  logic [53:0] u_prod;
  logic [7:0]  n_q;
  logic [29:0] frac_q;
  logic [59:0] x_prod;
  gsdy_pkg::arg_t arg_q;

  assign iv[0] = cfg_i.inv_var_x;
  assign iv[1] = cfg_i.inv_var_y;
  assign iv[2] = cfg_i.inv_var_z;
  assign iv[3] = cfg_i.inv_var_t;

  // unused axes contribute a zero term
  always_comb begin
    mag_d[0] = off_mag(req_i.coord_x, cfg_i.center_x);
    mag_d[1] = off_mag(req_i.coord_y, cfg_i.center_y);
    mag_d[2] = (req_i.func == gsdy_pkg::FUNC_3D || req_i.func == gsdy_pkg::FUNC_4D) ?
               off_mag(req_i.coord_z, cfg_i.center_z) : '0;
    mag_d[3] = (req_i.func == gsdy_pkg::FUNC_4D) ? off_mag(req_i.t_offset, 32'd0) : '0;
  end

  for (genvar i = 0; i < 4; i++) begin : g_term
    logic [64:0] full;
    assign full      = {1'b0, hi_q[i]} + {33'd0, lo_q[i][63:32]};
    assign term_d[i] = (full > 65'(gsdy_pkg::TERM_CAP)) ? gsdy_pkg::TERM_CAP : full[40:0];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        mag_q[i]  <= mag_d[i];
        sq_q[i]   <= 64'(mag_q[i]) * 64'(mag_q[i]);
        hi_q[i]   <= 64'(sq_q[i][63:32]) * 64'(iv[i]);
        lo_q[i]   <= 64'(sq_q[i][31:0]) * 64'(iv[i]);
        term_q[i] <= term_d[i];
      end
    end
  end

  always_comb begin
    sum    = 43'(term_q[0]) + 43'(term_q[1]) + 43'(term_q[2]) + 43'(term_q[3]);
    half   = sum[42:1];
    e_d    = (half > 42'(gsdy_pkg::E_CLAMP)) ? gsdy_pkg::E_CLAMP : half[22:0];
    neg5_d = term_q[1] < gsdy_pkg::ONE_Q16;
    m5_d   = neg5_d ? (gsdy_pkg::ONE_Q16 - term_q[1]) : (term_q[1] - gsdy_pkg::ONE_Q16);
    u_prod = 54'(e_q) * 54'(gsdy_pkg::LOG2E_Q30);
    x_prod = 60'(frac_q) * 60'(gsdy_pkg::LN2_Q30);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q  <= {zero_q[2:0], req_i.func == gsdy_pkg::FUNC_1D};
      e_q     <= e_d;
      m5_q    <= m5_d;
      neg5_q  <= neg5_d;
      zero5_q <= zero_q[3];
      n_q     <= u_prod[53:46];
      frac_q  <= u_prod[45:16];
      m6_q    <= m5_q;
      neg6_q  <= neg5_q;
      zero6_q <= zero5_q;
      arg_q.x    <= x_prod[59:30];
      arg_q.n    <= n_q;
      arg_q.m    <= m6_q;
      arg_q.neg  <= neg6_q;
      arg_q.zero <= zero6_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[5:0], valid_i};
    end
  end

  assign valid_o = vld_q[6];
  assign arg_o   = arg_q;

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(vld_q)) else $error("valid bits moved during stall");

endmodule

FILE: sv/gsdy_exp.sv
// exp(-x) by an 8-step Horner pipeline, then the 2^-n shift (17 stages).
module gsdy_exp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  gsdy_pkg::arg_t  arg_i,
  output logic            valid_o,
  output gsdy_pkg::expo_t exp_o
);

  localparam int unsigned NSTG = 2 * gsdy_pkg::HSTEPS + 1;

  typedef struct packed {
    logic        zero;
    logic        neg;
    logic [40:0] m;
    logic [7:0]  n;
    logic [29:0] x;
    logic [30:0] acc;   // product term after the multiply stage, t after the divide stage
  } horner_t;

  logic [NSTG-1:0] vld_q;
  horner_t cur [gsdy_pkg::HSTEPS+1];
  horner_t a_q [gsdy_pkg::HSTEPS];
  horner_t b_q [gsdy_pkg::HSTEPS];
  horner_t last;
  logic [32:0] shifted;
  gsdy_pkg::expo_t exp_q;

  always_comb begin
    cur[0].zero = arg_i.zero;
    cur[0].neg  = arg_i.neg;
    cur[0].m    = arg_i.m;
    cur[0].n    = arg_i.n;
    cur[0].x    = arg_i.x;
    cur[0].acc  = gsdy_pkg::ONE30;
  end

  for (genvar i = 0; i < gsdy_pkg::HSTEPS; i++) begin : g_step
    logic [60:0] pa, pb;
    horner_t a_d, b_d;

    always_comb begin
      pa     = 61'(cur[i].x) * 61'(cur[i].acc);
      a_d    = cur[i];
      a_d.acc = {1'b0, pa[59:30]};
    end

    always_comb begin
      pb      = 61'(a_q[i].acc[29:0]) * 61'(gsdy_pkg::DIV_MUL[i]);
      b_d     = a_q[i];
      b_d.acc = gsdy_pkg::ONE30 - {1'b0, 30'(pb >> gsdy_pkg::DIV_SHIFT[i])};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a_q[i] <= a_d;
        b_q[i] <= b_d;
      end
    end

    assign cur[i+1] = b_q[i];
  end

  assign last    = cur[gsdy_pkg::HSTEPS];
  assign shifted = {last.acc, 2'b00} >> last.n;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      exp_q.zero <= last.zero;
      exp_q.neg  <= last.neg;
      exp_q.m    <= last.m;
      exp_q.g    <= (last.n > gsdy_pkg::MAX_SHIFT) ? 33'd0 : shifted;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NSTG-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[NSTG-1];
  assign exp_o   = exp_q;

  a_g_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> exp_q.g <= 33'h1_0000_0000) else $error("exp result above 1.0");

endmodule

FILE: sv/gsdy_out.sv
// Norm and ivy scaling, y-factor product and saturation (5 stages, last is the output register).
module gsdy_out (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  gsdy_pkg::expo_t    exp_i,
  input  gsdy_pkg::cfg_t     cfg_i,
  output logic               valid_o,
  output logic signed [47:0] kernel_value_o,
  output logic               saturated_o
);

  logic [4:0]  vld_q;
  logic [64:0] pa;
  logic [63:0] pb;
  logic [31:0] a_q;
  logic [47:0] b_q;
  logic [64:0] ph_q, pl_q;
  logic [88:0] full;
  logic [72:0] mag_q;
  logic [3:0]  zero_q, neg_q;
  logic [40:0] m1_q, m2_q;
  logic [47:0] kv_d, kv_q;
  logic        sat_d, sat_q;

  assign pa   = 65'(cfg_i.norm_factor) * 65'(exp_i.g);
  assign pb   = 64'(a_q) * 64'(cfg_i.inv_var_y);
  assign full = {ph_q, 24'd0} + 89'(pl_q);

  always_comb begin
    kv_d  = '0;
    sat_d = 1'b0;
    if (zero_q[3]) begin
      kv_d = '0;
    end else if (neg_q[3]) begin
      if (mag_q > gsdy_pkg::NEG_MAG) begin
        kv_d  = gsdy_pkg::KV_NEG_MIN;
        sat_d = 1'b1;
      end else begin
        kv_d = 48'd0 - mag_q[47:0];
      end
    end else begin
      if (mag_q > gsdy_pkg::POS_MAX) begin
        kv_d  = gsdy_pkg::KV_POS_MAX;
        sat_d = 1'b1;
      end else begin
        kv_d = mag_q[47:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q    <= pa[63:32];
      b_q    <= pb[63:16];
      ph_q   <= 65'(b_q[47:24]) * 65'(m2_q);
      pl_q   <= 65'(b_q[23:0]) * 65'(m2_q);
      mag_q  <= full[88:16];
      m1_q   <= exp_i.m;
      m2_q   <= m1_q;
      zero_q <= {zero_q[2:0], exp_i.zero};
      neg_q  <= {neg_q[2:0], exp_i.neg};
      kv_q   <= kv_d;
      sat_q  <= sat_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  assign valid_o        = vld_q[4];
  assign kernel_value_o = kv_q;
  assign saturated_o    = sat_q;

  a_sat_extreme: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && sat_q |-> (kv_q == gsdy_pkg::KV_POS_MAX || kv_q == gsdy_pkg::KV_NEG_MIN))
    else $error("saturated result not at range limit");

  a_zero_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && vld_q[3] && zero_q[3] |=> kv_q == 48'd0 && !sat_q)
    else $error("1D mode gave nonzero result");

endmodule

FILE: sv/gaussian_second_derivative_y_eval_unit.sv
// Top level of the Gaussian second y-derivative evaluation unit.
//
//  channel  dir  protocol       payload
//  req_i    in   valid/ready    func, coord_x, coord_y, coord_z, t_offset
//  rsp_o    out  valid/ready    kernel_value (Q24.24), saturated
//  APB      in   psel/penable   8 x 32-bit registers at 4*i, pready tied high
//
// One request per cycle while rsp_o is not stalled; each request runs through
// 7 argument stages, 16 Horner stages plus shift and 5 scaling/saturation stages.
// The depth is set by the Horner recurrence: one multiply and one reciprocal multiply
// per step. Reset clears the valid bits and loads the register reset values.
// A stall on rsp_o freezes every stage at once; req_i.ready drops in the same cycle.
module gaussian_second_derivative_y_eval_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  gsdy_req_if.sink                    req_i,
  gsdy_rsp_if.source                  rsp_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gsdy_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  gsdy_pkg::cfg_t  cfg;
  gsdy_pkg::req_t  req;
  gsdy_pkg::arg_t  arg;
  gsdy_pkg::expo_t expo;
  logic            en;
  logic            arg_vld, exp_vld;

  // whole pipe advances unless a finished result is held
  assign en          = !rsp_o.valid || rsp_o.ready;
  assign req_i.ready = en;

  assign req.func     = req_i.func;
  assign req.coord_x  = req_i.coord_x;
  assign req.coord_y  = req_i.coord_y;
  assign req.coord_z  = req_i.coord_z;
  assign req.t_offset = req_i.t_offset;

  gsdy_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // offsets, squared terms, exponent split
  gsdy_arg u_arg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (req_i.valid),
    .req_i   (req),
    .cfg_i   (cfg),
    .valid_o (arg_vld),
    .arg_o   (arg)
  );

  // exp(-e) approximation
  gsdy_exp u_exp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (arg_vld),
    .arg_i   (arg),
    .valid_o (exp_vld),
    .exp_o   (expo)
  );

  // scaling, y factor, saturation and output register
  gsdy_out u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .valid_i        (exp_vld),
    .exp_i          (expo),
    .cfg_i          (cfg),
    .valid_o        (rsp_o.valid),
    .kernel_value_o (rsp_o.kernel_value),
    .saturated_o    (rsp_o.saturated)
  );

endmodule
